>>> design/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the WAV header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    localparam int POS_BITS = 32;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [32:0] FIRST_CHUNK = 33'd12;
    localparam logic [POS_BITS-1:0] MIN_FILE = POS_BITS'(44);
    localparam logic [4:0]  FMT_BYTES = 5'd16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE = 3'd2;
    localparam logic [2:0] ST_NO_CHUNK = 3'd3;
    localparam logic [2:0] ST_BAD_FMT  = 3'd4;
    localparam logic [2:0] ST_BAD_BITS = 3'd5;

    // one finished file, handed from the byte front end to the evaluator
    typedef struct packed {
        logic [POS_BITS-1:0] size;
        logic [1:0]          riff_wave;
        logic                fmt_seen;
        logic [POS_BITS-1:0] fmt_start;
        logic [127:0]        fmt_bytes;
        logic                data_found;
        logic [POS_BITS-1:0] body_start;
        logic [31:0]         body_len;
    } wavhp_job_t;

endpackage

>>> design/wavhp_front.sv
// ----------------------------------------------------------------------------
// wavhp_front
// Byte front end: tag checks, chunk walk and fmt body capture, one byte a cycle while the queue is not full.
// ----------------------------------------------------------------------------
module wavhp_front
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_is_last,
    input  logic        q_full,
    output logic        q_push,
    output wavhp_job_t  q_job
);

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [32:0]         nxt_reg, nxt_next;
    logic [63:0]         win_reg, win_next;
    logic [1:0]          rw_reg, rw_next;
    logic [POS_BITS-1:0] fstart_reg, fstart_next;
    logic                fseen_reg, fseen_next;
    logic                dfound_reg, dfound_next;
    logic [127:0]        ff_reg, ff_next;
    logic [POS_BITS-1:0] doff_reg, doff_next;
    logic [31:0]         dsize_reg, dsize_next;

    logic                take;
    logic                accept;
    logic [POS_BITS:0]   fdiff;
    logic                hdr;
    logic [31:0]         sz;
    logic [33:0]         nx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign take    = (pos_reg != POS_MAX);

    always_comb begin
        pos_next    = pos_reg;
        nxt_next    = nxt_reg;
        win_next    = win_reg;
        rw_next     = rw_reg;
        fstart_next = fstart_reg;
        fseen_next  = fseen_reg;
        dfound_next = dfound_reg;
        ff_next     = ff_reg;
        doff_next   = doff_reg;
        dsize_next  = dsize_reg;
        fdiff       = {1'b0, pos_reg} - {1'b0, fstart_reg};
        win_next    = take ? {win_reg[55:0], s_file_byte} : win_reg;
        sz          = {win_next[7:0], win_next[15:8], win_next[23:16], win_next[31:24]};
        nx          = 34'(pos_reg) + 34'd1 + 34'(sz) + 34'(sz[0]);
        hdr         = !dfound_reg && (34'(pos_reg) == 34'(nxt_reg) + 34'd7);
        if (take) begin
            if (pos_reg == POS_BITS'(3) && win_next[31:0] == TAG_RIFF) begin
                rw_next[0] = 1'b1;
            end
            if (pos_reg == POS_BITS'(11) && win_next[31:0] == TAG_WAVE) begin
                rw_next[1] = 1'b1;
            end
            if (fseen_reg && fdiff[POS_BITS:4] == '0) begin
                ff_next[fdiff[3:0]*8 +: 8] = ff_reg[fdiff[3:0]*8 +: 8] | s_file_byte;
            end
            if (hdr) begin
                if (win_next[63:32] == TAG_FMT) begin
                    fstart_next = pos_reg + 1'b1;
                    fseen_next  = 1'b1;
                    ff_next     = '0;
                end else if (win_next[63:32] == TAG_DATA) begin
                    dfound_next = 1'b1;
                    doff_next   = pos_reg + 1'b1;
                    dsize_next  = sz;
                end
                nxt_next = nx[33] ? '1 : nx[32:0];
            end
            pos_next = pos_reg + 1'b1;
        end
    end

    always_comb begin
        q_push            = accept && s_is_last;
        q_job.size        = pos_next;
        q_job.riff_wave   = rw_next;
        q_job.fmt_seen    = fseen_next;
        q_job.fmt_start   = fstart_next;
        q_job.fmt_bytes   = ff_next;
        q_job.data_found  = dfound_next;
        q_job.body_start  = doff_next;
        q_job.body_len    = dsize_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_is_last)) begin
            pos_reg    <= '0;
            nxt_reg    <= FIRST_CHUNK;
            win_reg    <= '0;
            rw_reg     <= '0;
            fstart_reg <= '0;
            fseen_reg  <= 1'b0;
            dfound_reg <= 1'b0;
            ff_reg     <= '0;
            doff_reg   <= '0;
            dsize_reg  <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            nxt_reg    <= nxt_next;
            win_reg    <= win_next;
            rw_reg     <= rw_next;
            fstart_reg <= fstart_next;
            fseen_reg  <= fseen_next;
            dfound_reg <= dfound_next;
            ff_reg     <= ff_next;
            doff_reg   <= doff_next;
            dsize_reg  <= dsize_next;
        end
    end

endmodule

>>> design/wavhp_queue.sv
// ----------------------------------------------------------------------------
// wavhp_queue
// Two-entry queue of finished-file records between front end and evaluator.
// ----------------------------------------------------------------------------
module wavhp_queue
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wavhp_job_t  push_job,
    input  logic        pop,
    output wavhp_job_t  pop_job,
    output logic        full,
    output logic        empty
);

    wavhp_job_t  mem_reg [2];
    logic        wr_reg;
    logic        rd_reg;
    logic [1:0]  cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_job = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_reg <= !wr_reg;
            end
            if (pop && !empty) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

>>> design/wavhp_back.sv
// ----------------------------------------------------------------------------
// wavhp_back
// Evaluator: status and format decode, serial loop-end division, result register.
// ----------------------------------------------------------------------------
module wavhp_back
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        loop_on,
    input  logic        q_empty,
    output logic        q_pop,
    input  wavhp_job_t  q_job,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_stereo,
    output logic        m_wide_samples,
    output logic [30:0] m_sample_rate,
    output logic [31:0] m_data_start,
    output logic [30:0] m_data_length,
    output logic [30:0] m_loop_end_frame,
    output logic        m_loop_end_valid
);

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_HOLD} state_t;

    state_t      state_reg;
    wavhp_job_t  job_reg;
    logic [15:0] div_reg;
    logic [15:0] rem_reg;
    logic [30:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  st_reg;
    logic        stereo_reg, wide_reg, lev_reg;
    logic [30:0] rate_reg, len_reg;
    logic [31:0] start_reg;

    logic [POS_BITS-1:0] fd;
    logic [4:0]  avail;
    logic [15:0] f_fmt, f_ch, f_align, f_bits;
    logic [31:0] f_rate;
    logic [2:0]  st;
    logic [16:0] shifted;
    logic [17:0] trial;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb begin
        fd    = job_reg.size - job_reg.fmt_start;
        avail = '0;
        if (job_reg.fmt_seen && job_reg.size > job_reg.fmt_start) begin
            avail = (fd > POS_BITS'(FMT_BYTES)) ? FMT_BYTES : fd[4:0];
        end
        f_fmt   = (avail >= 5'd2)  ? job_reg.fmt_bytes[15:0]    : '0;
        f_ch    = (avail >= 5'd4)  ? job_reg.fmt_bytes[31:16]   : '0;
        f_rate  = (avail >= 5'd8)  ? job_reg.fmt_bytes[63:32]   : '0;
        f_align = (avail >= 5'd14) ? job_reg.fmt_bytes[111:96]  : '0;
        f_bits  = (avail >= 5'd16) ? job_reg.fmt_bytes[127:112] : '0;
        if (job_reg.size < MIN_FILE) begin
            st = ST_SHORT;
        end else if (job_reg.riff_wave != 2'b11) begin
            st = ST_NOT_WAVE;
        end else if (!job_reg.fmt_seen || !job_reg.data_found
                     || job_reg.body_len == '0 || job_reg.body_len[31]) begin
            st = ST_NO_CHUNK;
        end else if (f_fmt != 16'd1 || f_ch < 16'd1 || f_ch > 16'd2
                     || f_rate == '0 || f_rate[31]) begin
            st = ST_BAD_FMT;
        end else if (f_bits != 16'd8 && f_bits != 16'd16) begin
            st = ST_BAD_BITS;
        end else begin
            st = ST_OK;
        end
        shifted = {rem_reg, quo_reg[30]};
        trial   = {1'b0, shifted} - {2'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_job;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    st_reg     <= st;
                    stereo_reg <= 1'b0;
                    wide_reg   <= 1'b0;
                    rate_reg   <= '0;
                    start_reg  <= '0;
                    len_reg    <= '0;
                    quo_reg    <= '0;
                    lev_reg    <= 1'b0;
                    state_reg  <= S_HOLD;
                    if (st == ST_OK) begin
                        stereo_reg <= (f_ch == 16'd2);
                        wide_reg   <= (f_bits == 16'd16);
                        rate_reg   <= f_rate[30:0];
                        start_reg  <= 32'(job_reg.body_start);
                        len_reg    <= job_reg.body_len[30:0];
                        if (loop_on && f_align != '0) begin
                            lev_reg   <= 1'b1;
                            div_reg   <= f_align;
                            rem_reg   <= '0;
                            quo_reg   <= job_reg.body_len[30:0];
                            cnt_reg   <= 5'd30;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (!trial[17]) begin
                        rem_reg <= trial[15:0];
                    end else begin
                        rem_reg <= shifted[15:0];
                    end
                    quo_reg <= {quo_reg[29:0], !trial[17]};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = (state_reg == S_HOLD);
    assign m_status         = st_reg;
    assign m_stereo         = stereo_reg;
    assign m_wide_samples   = wide_reg;
    assign m_sample_rate    = rate_reg;
    assign m_data_start     = start_reg;
    assign m_data_length    = len_reg;
    assign m_loop_end_frame = quo_reg;
    assign m_loop_end_valid = lev_reg;

endmodule

>>> design/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE PCM header parser: one file byte per request, one result per file.
// ----------------------------------------------------------------------------
//  channel   ports                                 direction
//  s_        s_file_byte, s_is_last                in, one file byte
//  m_        m_status .. m_loop_end_valid          out, one per file
//  cfg_      cfg_loop_on                           in, loop enable register
//
//  Bytes are taken one per cycle while the two-entry file queue has room.
//  Per file result: dequeue, evaluate, then the bit-serial loop-end divider when
//  looping applies; the result is then held until m_ready.
//  Reset is synchronous, active low; loop_on resets to 1.
//  The byte side stalls only when two finished files wait in the queue.
// ----------------------------------------------------------------------------
module wav_header_parser
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_stereo,
    output logic        m_wide_samples,
    output logic [30:0] m_sample_rate,
    output logic [31:0] m_data_start,
    output logic [30:0] m_data_length,
    output logic [30:0] m_loop_end_frame,
    output logic        m_loop_end_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_loop_on
);

    logic        loop_on_reg;
    logic        q_full, q_empty, q_push, q_pop;
    wavhp_job_t  push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_on_reg <= 1'b1;
        end else if (cfg_valid) begin
            loop_on_reg <= cfg_loop_on;
        end
    end

    wavhp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_file_byte (s_file_byte),
        .s_is_last   (s_is_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    wavhp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    wavhp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .loop_on          (loop_on_reg),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_job            (pop_job),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stereo         (m_stereo),
        .m_wide_samples   (m_wide_samples),
        .m_sample_rate    (m_sample_rate),
        .m_data_start     (m_data_start),
        .m_data_length    (m_data_length),
        .m_loop_end_frame (m_loop_end_frame),
        .m_loop_end_valid (m_loop_end_valid)
    );

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_BAD_BITS))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_sample_rate == '0 && m_data_start == '0
            && m_data_length == '0 && !m_loop_end_valid && !m_stereo && !m_wide_samples))
        else $error("error result carries format fields");

    a_no_loop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_loop_end_valid) |-> (m_loop_end_frame == '0))
        else $error("loop end set without valid");

    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (m_sample_rate != '0 && m_data_length != '0))
        else $error("ok result with empty rate or length");

endmodule

>>> dv/tb_wav_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_header_parser
// Streams generated WAV files, well-formed and damaged, through the parser one
// byte per request under several idle and stall mixes. A scoreboard predicts
// each file's result and checks the block's results in order.
// ----------------------------------------------------------------------------
module tb_wav_header_parser;
    import wavhp_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic        stereo;
        logic        wide;
        logic [30:0] rate;
        logic [31:0] start;
        logic [30:0] length;
        logic [30:0] loop_end;
        logic        loop_valid;
    } wav_result_t;

    class wav_scoreboard;
        bit                loop_on = 1'b1;
        longint unsigned   pos, next_hdr, fmt_at, data_off, data_sz;
        logic [63:0]       window;
        bit [1:0]          tags;
        bit                fmt_seen, data_found;
        logic [127:0]      fmt_body;
        wav_result_t       pending_q[$];
        int                mismatches;

        function new();
            clear();
        endfunction

        function void clear();
            pos = 0; next_hdr = FIRST_CHUNK; window = '0; tags = '0;
            fmt_at = 0; fmt_seen = 0; data_found = 0; fmt_body = '0;
            data_off = 0; data_sz = 0;
        endfunction

        function longint unsigned fmt_field(int off, int len, longint unsigned avail);
            longint unsigned v;
            v = 0;
            if (off + len > avail) return 0;
            for (int k = 0; k < len; k++)
                v |= longint'(fmt_body[(off + k) * 8 +: 8]) << (8 * k);
            return v;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            longint unsigned p, sz, nx, avail, ftag, ch, rate, align, bits;
            logic [31:0] lo;
            wav_result_t r;
            if (pos < POS_MAX) begin
                p = pos;
                window = {window[55:0], b};
                if (p == 3 && window[31:0] == TAG_RIFF) tags[0] = 1'b1;
                if (p == 11 && window[31:0] == TAG_WAVE) tags[1] = 1'b1;
                if (fmt_seen && p >= fmt_at && p - fmt_at < FMT_BYTES)
                    fmt_body[(p - fmt_at) * 8 +: 8] = b;
                if (!data_found && p == next_hdr + 7) begin
                    lo = window[31:0];
                    sz = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
                    if (window[63:32] == TAG_FMT) begin
                        fmt_at = p + 1; fmt_seen = 1; fmt_body = '0;
                    end else if (window[63:32] == TAG_DATA) begin
                        data_found = 1; data_off = p + 1; data_sz = sz;
                    end
                    nx = p + 1 + sz + (sz & 1);
                    next_hdr = (nx > 64'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : nx;
                end
                pos = p + 1;
            end
            if (!last) return;
            avail = 0;
            if (fmt_seen && pos > fmt_at) avail = (pos - fmt_at > 16) ? 16 : pos - fmt_at;
            ftag  = fmt_field(0, 2, avail);
            ch    = fmt_field(2, 2, avail);
            rate  = fmt_field(4, 4, avail);
            align = fmt_field(12, 2, avail);
            bits  = fmt_field(14, 2, avail);
            r = '{default: '0};
            if (pos < MIN_FILE) r.status = ST_SHORT;
            else if (tags != 2'b11) r.status = ST_NOT_WAVE;
            else if (!fmt_seen || !data_found || data_sz == 0 || data_sz > 32'h7FFF_FFFF)
                r.status = ST_NO_CHUNK;
            else if (ftag != 1 || ch < 1 || ch > 2 || rate == 0 || rate > 32'h7FFF_FFFF)
                r.status = ST_BAD_FMT;
            else if (bits != 8 && bits != 16) r.status = ST_BAD_BITS;
            else begin
                r.status = ST_OK;
                r.stereo = (ch == 2);
                r.wide   = (bits == 16);
                r.rate   = rate[30:0];
                r.start  = data_off[31:0];
                r.length = data_sz[30:0];
                if (loop_on && align != 0) begin
                    sz = data_sz / align;
                    r.loop_end = sz[30:0];
                    r.loop_valid = 1'b1;
                end
            end
            pending_q.push_back(r);
            clear();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(wav_result_t got);
            wav_result_t e;
            if (pending_q.size() == 0) begin
                flag("result with no file pending");
                return;
            end
            e = pending_q.pop_front();
            if (got.status != e.status)
                flag($sformatf("status exp %0d got %0d", e.status, got.status));
            if (got.stereo != e.stereo)
                flag($sformatf("stereo exp %0d got %0d", e.stereo, got.stereo));
            if (got.wide != e.wide)
                flag($sformatf("wide exp %0d got %0d", e.wide, got.wide));
            if (got.rate != e.rate)
                flag($sformatf("rate exp %0d got %0d", e.rate, got.rate));
            if (got.start != e.start)
                flag($sformatf("data_start exp %0d got %0d", e.start, got.start));
            if (got.length != e.length)
                flag($sformatf("data_length exp %0d got %0d", e.length, got.length));
            if (got.loop_end != e.loop_end)
                flag($sformatf("loop_end exp %0d got %0d", e.loop_end, got.loop_end));
            if (got.loop_valid != e.loop_valid)
                flag($sformatf("loop_valid exp %0d got %0d", e.loop_valid, got.loop_valid));
        endfunction
    endclass

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_GAP   = 40;
    localparam int PHASE_BYTES = 170;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_file_byte = '0;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_stereo, m_wide_samples, m_loop_end_valid;
    logic [30:0] m_sample_rate, m_data_length, m_loop_end_frame;
    logic [31:0] m_data_start;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_loop_on = 1'b1;

    wav_scoreboard sb = new();
    logic [7:0]    wav_q[$];
    int            idle_pct, stall_pct, quiet_cycles, bytes_sent, files_sent;
    int            results_seen;

    always #5 aclk = ~aclk;

    wav_header_parser dut (.*);

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_file_byte, s_is_last);
            if (cfg_valid && cfg_ready) sb.loop_on = cfg_loop_on;
            if (m_valid && m_ready) begin
                results_seen++;
                sb.check_result('{m_status, m_stereo, m_wide_samples, m_sample_rate,
                                  m_data_start, m_data_length, m_loop_end_frame,
                                  m_loop_end_valid});
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_file_byte <= b;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < wav_q.size(); i++) send_byte(wav_q[i], i == wav_q.size() - 1);
        files_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_loop_on(logic v);
        cfg_valid <= 1'b1;
        cfg_loop_on <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_tag(logic [31:0] t);
        for (int k = 3; k >= 0; k--) wav_q.push_back(t[k * 8 +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int k = 0; k < n; k++) wav_q.push_back(v[k * 8 +: 8]);
    endfunction

    function automatic void put_fmt(logic [15:0] ftag, logic [15:0] ch, logic [31:0] rate,
                                    logic [15:0] align, logic [15:0] bits, int len);
        logic [127:0] body;
        body = {bits, align, 32'($urandom), rate, ch, ftag};
        put_tag(TAG_FMT);
        put_le(len, 4);
        for (int k = 0; k < len; k++)
            wav_q.push_back(k < 16 ? body[k * 8 +: 8] : 8'($urandom));
        if (len % 2) wav_q.push_back(8'($urandom));
    endfunction

    function automatic void build_wav(bit riff_ok, bit wave_ok, bit junk, int fmt_count,
                                      logic [15:0] ftag, logic [15:0] ch, logic [31:0] rate,
                                      logic [15:0] align, logic [15:0] bits, int fmt_len,
                                      logic [31:0] dsize, int body_n);
        int n;
        wav_q.delete();
        put_tag(riff_ok ? TAG_RIFF : TAG_RIFF ^ (32'h1 << $urandom_range(31)));
        put_le($urandom, 4);
        put_tag(wave_ok ? TAG_WAVE : TAG_WAVE ^ (32'h1 << $urandom_range(31)));
        if (junk) begin
            n = $urandom_range(0, 7);
            put_tag($urandom);
            put_le(n, 4);
            repeat (n + n % 2) wav_q.push_back(8'($urandom));
        end
        for (int f = 1; f < fmt_count; f++)
            put_fmt(16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                    16'($urandom), 16);
        if (fmt_count > 0) put_fmt(ftag, ch, rate, align, bits, fmt_len);
        put_tag(TAG_DATA);
        put_le(dsize, 4);
        repeat (body_n) wav_q.push_back(8'($urandom));
    endfunction

    task automatic random_file();
        logic [15:0] ftag, ch, align, bits;
        logic [31:0] rate, dsize;
        int          fmt_len, cut;
        bit          clean;
        clean = ($urandom_range(99) < 75);
        ftag  = (clean || $urandom_range(1)) ? 16'd1 : 16'($urandom_range(0, 3));
        ch    = (clean || $urandom_range(1)) ? 16'($urandom_range(1, 2)) : 16'($urandom);
        rate  = $urandom_range(1, 96000);
        if (!clean) begin
            case ($urandom_range(3))
                0: rate = 0;
                1: rate = 32'h8000_0000 | $urandom;
                2: rate = {1'b0, 31'($urandom)};
                default: ;
            endcase
        end
        align = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        bits  = (clean || $urandom_range(1)) ? ($urandom_range(1) ? 16'd16 : 16'd8)
                                             : 16'($urandom);
        fmt_len = clean ? ($urandom_range(3) == 0 ? 18 : 16) : $urandom_range(0, 20);
        dsize = $urandom_range(1, 4000);
        if (!clean) begin
            case ($urandom_range(3))
                0: dsize = 0;
                1: dsize = $urandom;
                default: ;
            endcase
        end
        build_wav(clean || $urandom_range(3) != 0, clean || $urandom_range(3) != 0,
                  $urandom_range(3) == 0, clean ? 1 : $urandom_range(0, 2),
                  ftag, ch, rate, align, bits, fmt_len, dsize, $urandom_range(0, 6));
        if (!clean && $urandom_range(2) == 0) begin
            // either a huge chunk size at byte 16, so the walk never reaches data, or a file cut short
            if ($urandom_range(1)) begin
                wav_q[16] = 8'hFF; wav_q[17] = 8'hFF; wav_q[18] = 8'hFF; wav_q[19] = 8'hFF;
            end else begin
                cut = $urandom_range(1, wav_q.size() - 1);
                wav_q = wav_q[0:wav_q.size() - 1 - cut];
            end
        end
        send_file();
    endtask

    task automatic directed();
        build_wav(1, 1, 0, 1, 1, 1, 8000, 1, 8, 16, 100, 4);           send_file();
        build_wav(1, 1, 1, 1, 1, 2, 32'h7FFF_FFFF, 4, 16, 18, 32'h7FFF_FFFF, 2);
        send_file();
        wav_q = '{8'hFF};                                               send_file();
        build_wav(0, 1, 0, 1, 1, 1, 8000, 1, 8, 16, 10, 0);             send_file();
        build_wav(1, 0, 0, 1, 1, 1, 8000, 1, 8, 16, 10, 0);             send_file();
        build_wav(1, 1, 0, 0, 1, 1, 8000, 1, 8, 16, 10, 12);            send_file();
        build_wav(1, 1, 0, 1, 1, 1, 8000, 1, 8, 16, 0, 0);              send_file();
        build_wav(1, 1, 0, 1, 1, 1, 8000, 1, 8, 16, 32'h8000_0000, 0);  send_file();
        build_wav(1, 1, 0, 1, 3, 1, 8000, 1, 8, 16, 10, 0);             send_file();
        build_wav(1, 1, 0, 1, 1, 3, 8000, 1, 8, 16, 10, 0);             send_file();
        build_wav(1, 1, 0, 1, 1, 1, 0, 1, 8, 16, 10, 0);                send_file();
        build_wav(1, 1, 0, 1, 1, 1, 8000, 3, 24, 16, 10, 0);            send_file();
        build_wav(1, 1, 0, 1, 1, 2, 44100, 0, 16, 16, 10, 0);           send_file();
        build_wav(1, 1, 0, 2, 1, 1, 22050, 2, 16, 16, 10, 0);           send_file();
        build_wav(1, 1, 0, 1, 1, 1, 8000, 1, 8, 4, 10, 20);             send_file();
        build_wav(1, 1, 0, 1, 1, 2, 8000, 4, 16, 16, 10, 0);
        wav_q = wav_q[0:40];                                            send_file();
        wav_q = '{};
        repeat (60) wav_q.push_back(8'($urandom));                      send_file();
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_loop_on(1'b1);
        directed();
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            write_loop_on(1'(ph % 2));
            files_sent = 0;
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                random_file();
                if (files_sent == 4) drain();
            end
            drain();
        end
        write_loop_on(1'b1);
        drain();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
